/* hdl/crgtq_pkg.sv */
// Package for the coalescing ready-gated transmit queue.
// Holds field widths, the stream packing widths and the invalid-index code.
// No dependencies.
package crgtq_pkg;

    localparam int INST_W    = 2;
    localparam int TX_W      = 8;
    localparam int MASK_W    = 4;
    localparam int DISC_W    = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    localparam logic [TX_W-1:0]   TX_NONE  = 8'hFF;
    localparam logic [DISC_W-1:0] DISC_MAX = 3'd7;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef logic [INST_W-1:0] inst_t;
    typedef logic [TX_W-1:0]   tx_t;

endpackage

/* hdl/coalescing_ready_gated_tx_queue.sv */
// A new transaction is taken only while the sequencer is idle; a push scans one slot a
// cycle, a pop removes one head a cycle through the slot compare/shift step.
// The output register holds a result while the next transaction is being worked on.
// Reset (aresetn low, synchronous): queue empty, sequencer idle, no result pending.
//
// Top level of the coalescing ready-gated transmit queue. Depends on crgtq_pkg.
module coalescing_ready_gated_tx_queue #(
    parameter int SLOTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] instance_req, [9:2] tx_index, [13:10] ready_mask, [15:14] zero
    input  logic [crgtq_pkg::S_DATA_W-1:0] s_tdata,
    // [0] mode: 0 push/update, 1 pop
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] found, [2:1] out_instance, [10:3] out_tx_index, [11] push_dropped,
    // [14:12] discarded, [15] zero
    output logic [crgtq_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // slot storage; valid bits stay packed toward the head
    logic [SLOTS-1:0]    valid_reg;
    crgtq_pkg::inst_t    inst_reg [SLOTS];
    crgtq_pkg::tx_t      tx_reg   [SLOTS];

    // latched request
    crgtq_pkg::inst_t              req_inst_reg;
    crgtq_pkg::tx_t                req_tx_reg;
    logic [crgtq_pkg::MASK_W-1:0]  req_mask_reg;
    logic [SLOT_W-1:0]             scan_reg;

    // result under construction
    logic                          res_found_reg;
    crgtq_pkg::inst_t              res_inst_reg;
    crgtq_pkg::tx_t                res_tx_reg;
    logic                          res_drop_reg;
    logic [crgtq_pkg::DISC_W-1:0]  res_disc_reg;

    logic                          m_tvalid_reg;
    logic [crgtq_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic s_fire, out_free;

    // slot step: compare at scan slot for push, head test for pop
    logic scan_hit, scan_empty, head_live, head_ready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign scan_hit   = valid_reg[scan_reg] && (inst_reg[scan_reg] == req_inst_reg);
    assign scan_empty = !valid_reg[scan_reg];
    assign head_live  = valid_reg[0] && (tx_reg[0] != crgtq_pkg::TX_NONE);
    assign head_ready = req_mask_reg[inst_reg[0]];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == crgtq_pkg::MODE_POP) ? ST_POP : ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (scan_hit || scan_empty || scan_reg == LAST_SLOT) begin
                    state_next = ST_DONE;
                end
            end
            ST_POP: begin
                if (!head_live || head_ready) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_PUSH && scan_empty) begin
                valid_reg[scan_reg] <= 1'b1;
            end
            if (state_reg == ST_POP && head_live) begin
                valid_reg <= valid_reg >> 1;
            end
        end
    end

    // payload and sequencer datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_inst_reg  <= s_tdata[1:0];
            req_tx_reg    <= s_tdata[9:2];
            req_mask_reg  <= s_tdata[13:10];
            scan_reg      <= '0;
            res_found_reg <= 1'b0;
            res_inst_reg  <= '0;
            res_tx_reg    <= crgtq_pkg::TX_NONE;
            res_drop_reg  <= 1'b0;
            res_disc_reg  <= '0;
        end
        unique case (state_reg)
            ST_PUSH: begin
                if (scan_hit || scan_empty) begin
                    inst_reg[scan_reg] <= req_inst_reg;
                    tx_reg[scan_reg]   <= req_tx_reg;
                end else if (scan_reg == LAST_SLOT) begin
                    res_drop_reg <= 1'b1;
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            ST_POP: begin
                if (head_live) begin
                    if (head_ready) begin
                        res_found_reg <= 1'b1;
                        res_inst_reg  <= inst_reg[0];
                        res_tx_reg    <= tx_reg[0];
                    end else if (res_disc_reg != crgtq_pkg::DISC_MAX) begin
                        res_disc_reg <= res_disc_reg + 1'b1;
                    end
                    for (int i = 0; i < SLOTS - 1; i++) begin
                        inst_reg[i] <= inst_reg[i+1];
                        tx_reg[i]   <= tx_reg[i+1];
                    end
                    inst_reg[SLOTS-1] <= '0;
                    tx_reg[SLOTS-1]   <= crgtq_pkg::TX_NONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {1'b0, res_disc_reg, res_drop_reg, res_tx_reg,
                                    res_inst_reg, res_found_reg};
                end
            end
            default: ;
        endcase
    end

    // queue stays front-packed: valid bits form a run starting at the head
    a_front_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & (valid_reg + 1'b1)) == '0)
        else $error("slot valid bits not front-packed");

    // a result never reports both a found entry and a dropped push
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[11]))
        else $error("result flags both found and dropped");

    // a not-found result carries the empty entry
    a_none_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[10:3] == crgtq_pkg::TX_NONE
                                       && m_tdata[2:1] == '0))
        else $error("not-found result carries an entry");

    // a taken result is retired unless a new one loads behind it
    a_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && state_reg != ST_DONE) |=> !m_tvalid)
        else $error("result repeated after transaction");

endmodule

/* sim/coalescing_ready_gated_tx_queue_tb.sv */
// Self-checking testbench for the coalescing ready-gated transmit queue.
// Drives push/pop transactions with random idling and checks every result.
// Depends on crgtq_pkg and coalescing_ready_gated_tx_queue.
`timescale 1ns / 1ps

module coalescing_ready_gated_tx_queue_tb;

    localparam int SLOTS        = 4;
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 100;        // last requests go without idling
    localparam int DRAIN_CYCLES = SLOTS + 8;  // beyond the worst pop latency
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic                           mode;
        crgtq_pkg::inst_t               inst;
        crgtq_pkg::tx_t                 tx;
        logic [crgtq_pkg::MASK_W-1:0]   mask;
    } req_t;

    typedef struct packed {
        logic                           found;
        crgtq_pkg::inst_t               inst;
        crgtq_pkg::tx_t                 tx;
        logic                           dropped;
        logic [crgtq_pkg::DISC_W-1:0]   disc;
    } resp_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [crgtq_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [crgtq_pkg::M_DATA_W-1:0]   m_tdata;

    // Requests waiting to be driven, and results owed by the queue.
    req_t  req_queue[$];
    resp_t exp_resp_q[$];

    // Shadow copy of the slot array.
    logic             slot_valid_m [SLOTS];
    crgtq_pkg::inst_t slot_inst_m  [SLOTS];
    crgtq_pkg::tx_t   slot_tx_m    [SLOTS];

    int    err_count  = 0;
    int    cycle_count = 0;
    int    tx_gap = 0;
    int    rx_gap = 0;
    bit    in_taken = 1'b0;    // input transaction accepted at the last rising edge
    req_t  drv_req;
    resp_t mon_want;
    resp_t mon_got;

    coalescing_ready_gated_tx_queue #(
        .SLOTS(SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic add_request(input logic mode, input int inst, input int tx,
                               input int mask);
        req_t r;
        r.mode = mode;
        r.inst = crgtq_pkg::inst_t'(inst);
        r.tx   = crgtq_pkg::tx_t'(tx);
        r.mask = mask[crgtq_pkg::MASK_W-1:0];
        req_queue.push_back(r);
    endtask

    // Applies one transaction to the shadow slots and returns the result it owes.
    task automatic predict_queue_op(input req_t r, output resp_t e);
        bit placed;
        int i;
        e.found   = 1'b0;
        e.inst    = '0;
        e.tx      = crgtq_pkg::TX_NONE;
        e.dropped = 1'b0;
        e.disc    = '0;
        if (r.mode == crgtq_pkg::MODE_PUSH) begin
            // First slot holding the same instance or empty wins.
            placed = 1'b0;
            for (i = 0; i < SLOTS && !placed; i++) begin
                if (slot_valid_m[i] && slot_inst_m[i] == r.inst) begin
                    slot_tx_m[i] = r.tx;
                    placed = 1'b1;
                end else if (!slot_valid_m[i]) begin
                    slot_valid_m[i] = 1'b1;
                    slot_inst_m[i]  = r.inst;
                    slot_tx_m[i]    = r.tx;
                    placed = 1'b1;
                end
            end
            e.dropped = !placed;
        end else begin
            // Walk heads until a ready one, an empty head or an invalid index.
            while (!e.found && slot_valid_m[0] && slot_tx_m[0] != crgtq_pkg::TX_NONE) begin
                if (r.mask[slot_inst_m[0]]) begin
                    e.found = 1'b1;
                    e.inst  = slot_inst_m[0];
                    e.tx    = slot_tx_m[0];
                end else if (e.disc != crgtq_pkg::DISC_MAX) begin
                    e.disc = e.disc + 1'b1;
                end
                for (i = 0; i + 1 < SLOTS; i++) begin
                    slot_valid_m[i] = slot_valid_m[i+1];
                    slot_inst_m[i]  = slot_inst_m[i+1];
                    slot_tx_m[i]    = slot_tx_m[i+1];
                end
                slot_valid_m[SLOTS-1] = 1'b0;
                slot_inst_m[SLOTS-1]  = '0;
                slot_tx_m[SLOTS-1]    = crgtq_pkg::TX_NONE;
            end
        end
    endtask

    // Driver: a new input transaction goes out at the falling edge once the
    // previous one was taken; idle bursts stop for the tail of the run.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (req_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (req_queue.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 9);
                s_tvalid <= 1'b0;
            end else begin
                drv_req = req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_req.mode;
                s_tdata  <= {2'b00, drv_req.mask, drv_req.tx, drv_req.inst};
            end
        end
    end

    // Result-side backpressure in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (req_queue.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check the result transaction first, then predict the input one,
    // so a result leaving on the same edge matches an older expectation.
    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                mon_got.found   = m_tdata[0];
                mon_got.inst    = m_tdata[2:1];
                mon_got.tx      = m_tdata[10:3];
                mon_got.dropped = m_tdata[11];
                mon_got.disc    = m_tdata[14:12];
                if (exp_resp_q.size() == 0) begin
                    report_mismatch("unexpected result, m_tdata", m_tdata, -1);
                end else begin
                    mon_want = exp_resp_q.pop_front();
                    if (mon_got.found !== mon_want.found)
                        report_mismatch("found", mon_got.found, mon_want.found);
                    if (mon_got.inst !== mon_want.inst)
                        report_mismatch("out_instance", mon_got.inst, mon_want.inst);
                    if (mon_got.tx !== mon_want.tx)
                        report_mismatch("out_tx_index", mon_got.tx, mon_want.tx);
                    if (mon_got.dropped !== mon_want.dropped)
                        report_mismatch("push_dropped", mon_got.dropped, mon_want.dropped);
                    if (mon_got.disc !== mon_want.disc)
                        report_mismatch("discarded", mon_got.disc, mon_want.disc);
                end
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                predict_queue_op({s_tuser, s_tdata[1:0], s_tdata[9:2], s_tdata[13:10]},
                                 mon_want);
                exp_resp_q.push_back(mon_want);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("coalescing_ready_gated_tx_queue_tb: errors");
            $finish;
        end
    end

    initial begin
        int n;
        int pick;
        for (n = 0; n < SLOTS; n++) begin
            slot_valid_m[n] = 1'b0;
            slot_inst_m[n]  = '0;
            slot_tx_m[n]    = crgtq_pkg::TX_NONE;
        end

        // Directed part.
        add_request(crgtq_pkg::MODE_POP,  3, 255, 4'hF);   // pop on an empty queue
        add_request(crgtq_pkg::MODE_PUSH, 0, 8'h00, 0);
        add_request(crgtq_pkg::MODE_PUSH, 1, 8'hFF, 0);    // invalid index is still queued
        add_request(crgtq_pkg::MODE_PUSH, 2, 8'hAA, 0);
        add_request(crgtq_pkg::MODE_PUSH, 3, 8'h55, 0);
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'hF);     // head ready at once
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'hF);     // invalid-index head blocks
        add_request(crgtq_pkg::MODE_PUSH, 1, 8'h7E, 0);    // coalesce in place
        add_request(crgtq_pkg::MODE_PUSH, 2, 8'hFE, 0);
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'h0);     // nothing ready: drain, count
        add_request(crgtq_pkg::MODE_PUSH, 3, 8'h01, 0);
        add_request(crgtq_pkg::MODE_PUSH, 0, 8'h80, 0);
        add_request(crgtq_pkg::MODE_PUSH, 2, 8'h40, 0);
        add_request(crgtq_pkg::MODE_POP,  3, 255, 4'h4);   // discard two, then hit
        add_request(crgtq_pkg::MODE_PUSH, 3, 8'hFF, 0);
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'hF);
        add_request(crgtq_pkg::MODE_PUSH, 3, 8'h10, 0);
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'h8);
        add_request(crgtq_pkg::MODE_POP,  0, 0, 4'hF);     // empty again

        // Random part: mostly pushes with some invalid indexes, pops with
        // random ready masks; the fields a mode ignores are random too.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                add_request(crgtq_pkg::MODE_PUSH, $urandom_range(0, 3),
                            ($urandom_range(0, 11) == 0) ? 255 : $urandom_range(0, 255),
                            $urandom_range(0, 15));
            else
                add_request(crgtq_pkg::MODE_POP, $urandom_range(0, 3),
                            $urandom_range(0, 255),
                            ($urandom_range(0, 5) == 0) ? 4'hF : $urandom_range(0, 15));
        end

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (exp_resp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("coalescing_ready_gated_tx_queue_tb: clean");
        end else begin
            $display("coalescing_ready_gated_tx_queue_tb: errors");
        end
        $finish;
    end

endmodule

/* coalescing_ready_gated_tx_queue.f */
hdl/crgtq_pkg.sv
hdl/coalescing_ready_gated_tx_queue.sv
sim/coalescing_ready_gated_tx_queue_tb.sv
